>>> sv/assert_macros.svh
// Assertion macros shared by the waypoint stabilizer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define WTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define WTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/wts_pkg.sv
// Types and constants of the waypoint temporal stabilizer.
// Depends on nothing; used by every other file of the block but the assertion macros.
package wts_pkg;

  localparam int POS_W      = 16;
  localparam int DEPTH_W    = 4;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIVD_W     = 32;
  localparam int DIVS_W     = 17;
  localparam int DIST_W     = 17;
  localparam int D2_W       = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 2'd3;

  localparam logic                RST_ENABLE   = 1'b1;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH    = 4'd5;
  localparam logic [POS_W-1:0]    RST_MAX_STEP = 16'd480;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 17'd58982;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    DIV_MEAN_X,
    DIV_MEAN_Y,
    DIV_STEP_X,
    DIV_STEP_Y
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_RD, S_ACC,
    S_MX_GO, S_MX_WAIT, S_MY_GO, S_MY_WAIT,
    S_DIFF, S_SQUARE, S_SUM, S_CHECK,
    S_SQRT_GO, S_SQRT_WAIT, S_MUL,
    S_SX_GO, S_SX_WAIT, S_SY_GO, S_SY_WAIT,
    S_BLEND, S_BSUM, S_STAB_WR, S_FINISH, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     hist_wr;
    logic     stab_rd;
    logic     hist_rd;
    logic     j_inc;
    logic     acc;
    logic     div_go;
    logic     div_take;
    div_sel_e div_sel;
    logic     diff;
    logic     square;
    logic     d2_sum;
    logic     sqrt_go;
    logic     sqrt_take;
    logic     step_mul;
    logic     blend_mul;
    logic     blend_sum;
    logic     stab_wr;
    logic     finish;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic in_range;
    logic active;
    logic has_stable;
    logic more_j;
    logic len_ok;
    logic clamp;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

>>> sv/wts_in_if.sv
// Request channel carrying input waypoints.
// Depends on wts_pkg for the field width.
interface wts_in_if;
  logic                     valid;
  logic                     ready;
  logic [wts_pkg::POS_W-1:0] pos_x;
  logic [wts_pkg::POS_W-1:0] pos_y;
  logic                     frame_end;

  modport source (output valid, output pos_x, output pos_y, output frame_end, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input frame_end, output ready);
endinterface

>>> sv/wts_out_if.sv
// Request channel carrying stabilized waypoints.
// Depends on wts_pkg for the field width.
interface wts_out_if;
  logic                     valid;
  logic                     ready;
  logic [wts_pkg::POS_W-1:0] out_x;
  logic [wts_pkg::POS_W-1:0] out_y;
  logic                     out_last;

  modport source (output valid, output out_x, output out_y, output out_last, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_last, output ready);
endinterface

>>> sv/wts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wts_pkg for the operand widths.
module wts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wts_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [wts_pkg::DIVS_W-1:0]   divisor_i,
  output logic [wts_pkg::DIVD_W-1:0]   quotient_o,
  output logic                         done_o
);
  localparam int CNT_W = $clog2(wts_pkg::DIVD_W + 1);

  logic [wts_pkg::DIVD_W-1:0] quo_q;
  logic [wts_pkg::DIVS_W:0]   rem_q;
  logic [wts_pkg::DIVS_W-1:0] dvs_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;
  logic [wts_pkg::DIVS_W:0]   shifted;
  logic                       fits;

  assign shifted = {rem_q[wts_pkg::DIVS_W-1:0], quo_q[wts_pkg::DIVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(wts_pkg::DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
      quo_q <= {quo_q[wts_pkg::DIVD_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

>>> sv/wts_sqrt.sv
// Integer square root, one result bit per cycle.
// Depends on wts_pkg for the operand widths.
module wts_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wts_pkg::D2_W-1:0]    value_i,
  output logic [wts_pkg::DIST_W-1:0]  root_o,
  output logic                        done_o
);
  localparam int W = wts_pkg::D2_W + 1;

  logic [W-1:0] v_q, r_q, probe_q, trial;
  logic         busy_q, done_q;

  assign trial = r_q + probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && probe_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q     <= W'(value_i);
      r_q     <= '0;
      probe_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + probe_q;
      end else begin
        r_q <= r_q >> 1;
      end
      probe_q <= probe_q >> 2;
    end
  end

  assign root_o = r_q[wts_pkg::DIST_W-1:0];
  assign done_o = done_q;
endmodule

>>> sv/wts_datapath.sv
// Datapath: configuration, history and stable-frame memories, arithmetic.
// Depends on wts_pkg, wts_div and wts_sqrt.
module wts_datapath #(
  parameter int MAX_HISTORY = 8,
  parameter int MAX_POINTS  = 64,
  parameter int MIN_FRAMES  = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wts_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [wts_pkg::POS_W-1:0]         pos_x_i,
  input  logic [wts_pkg::POS_W-1:0]         pos_y_i,
  input  logic                              frame_end_i,
  input  wts_pkg::cmd_t                     cmd_i,
  output wts_pkg::sts_t                     sts_o,
  output logic [wts_pkg::POS_W-1:0]         out_x_o,
  output logic [wts_pkg::POS_W-1:0]         out_y_o,
  output logic                              out_last_o
);
  localparam int SLOT_W = $clog2(MAX_HISTORY);
  localparam int CNT_W  = $clog2(MAX_HISTORY + 1);
  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int IDX_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = wts_pkg::POS_W + CNT_W;
  localparam int PW     = wts_pkg::POS_W;
  localparam int WW     = wts_pkg::WEIGHT_W;

  // Configuration registers.
  logic                        en_q;
  logic [wts_pkg::DEPTH_W-1:0] depth_q;
  logic [PW-1:0]               ms_q;
  logic [WW-1:0]               wt_q;

  // History bookkeeping.
  logic [IDX_W-1:0]  hist_len_q [MAX_HISTORY];
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] head_q;
  logic [IDX_W-1:0]  stable_len_q;
  logic [IDX_W-1:0]  index_q;

  logic [PW-1:0] hist_x_mem [MAX_HISTORY][MAX_POINTS];
  logic [PW-1:0] hist_y_mem [MAX_HISTORY][MAX_POINTS];
  logic [PW-1:0] stab_x_mem [MAX_POINTS];
  logic [PW-1:0] stab_y_mem [MAX_POINTS];

  // Per-item working registers.
  logic [PW-1:0]    px_q, py_q, rx_q, ry_q, lx_q, ly_q, rd_x_q, rd_y_q;
  logic             fend_q;
  logic [SUM_W-1:0] sx_q, sy_q;
  logic [CNT_W-1:0] cnt_q, j_q;
  logic [PW-1:0]    magx_q, magy_q;
  logic             negx_q, negy_q;
  logic [31:0]      sqx_q, sqy_q, ms2_q, prodx_q, prody_q;
  logic [wts_pkg::D2_W-1:0]   d2_q;
  logic [wts_pkg::DIST_W-1:0] dist_q;
  logic [WW+PW-1:0] bx1_q, bx2_q, by1_q, by2_q;
  logic [PW-1:0]    out_x_q, out_y_q;
  logic             out_last_q;

  logic [CNT_W-1:0]  eff_depth, held;
  logic [CNT_W:0]    held_w;
  logic [SLOT_W:0]   slot_w;
  logic [SLOT_W-1:0] slot;
  logic [PT_W-1:0]   pt;
  logic              in_range, active;
  logic [IDX_W-1:0]  frame_len;
  logic [WW-1:0]     w_eff, w_inv;
  logic [WW+PW-1:0]  bsum_x, bsum_y;

  logic [wts_pkg::DIVD_W-1:0]  div_dividend, div_quo;
  logic [wts_pkg::DIVS_W-1:0]  div_divisor;
  logic                        div_done;
  logic [wts_pkg::DIST_W-1:0]  sqrt_root;
  logic                        sqrt_done;

  always_comb begin
    if (depth_q == '0) begin
      eff_depth = CNT_W'(1);
    end else if (32'(depth_q) > MAX_HISTORY) begin
      eff_depth = CNT_W'(MAX_HISTORY);
    end else begin
      eff_depth = CNT_W'(depth_q);
    end
    held_w = {1'b0, count_q} + (CNT_W+1)'(1);
    held   = (held_w > {1'b0, eff_depth}) ? eff_depth : CNT_W'(held_w);
    slot_w = {1'b0, head_q} + (SLOT_W+1)'(MAX_HISTORY) - (SLOT_W+1)'(j_q);
    if (slot_w >= (SLOT_W+1)'(MAX_HISTORY)) begin
      slot_w = slot_w - (SLOT_W+1)'(MAX_HISTORY);
    end
    slot = SLOT_W'(slot_w);
  end

  assign pt        = index_q[PT_W-1:0];
  assign in_range  = index_q < IDX_W'(MAX_POINTS);
  assign active    = 32'(held) >= MIN_FRAMES;
  assign frame_len = in_range ? index_q + IDX_W'(1) : IDX_W'(MAX_POINTS);
  assign w_eff     = (wt_q > wts_pkg::WEIGHT_ONE) ? wts_pkg::WEIGHT_ONE : wt_q;
  assign w_inv     = wts_pkg::WEIGHT_ONE - w_eff;
  assign bsum_x    = bx1_q + bx2_q;
  assign bsum_y    = by1_q + by2_q;

  assign sts_o.enabled    = en_q;
  assign sts_o.in_range   = in_range;
  assign sts_o.active     = active;
  assign sts_o.has_stable = index_q < stable_len_q;
  assign sts_o.more_j     = j_q < held;
  assign sts_o.len_ok     = index_q < hist_len_q[slot];
  assign sts_o.clamp      = d2_q > {1'b0, ms2_q};
  assign sts_o.div_done   = div_done;
  assign sts_o.sqrt_done  = sqrt_done;

  // Configuration and history state; a depth write restarts the history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= wts_pkg::RST_ENABLE;
      depth_q      <= wts_pkg::RST_DEPTH;
      ms_q         <= wts_pkg::RST_MAX_STEP;
      wt_q         <= wts_pkg::RST_WEIGHT;
      hist_len_q   <= '{default: '0};
      count_q      <= '0;
      head_q       <= '0;
      stable_len_q <= '0;
      index_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wts_pkg::CFG_ENABLE:   en_q <= cfg_data_i[0];
        wts_pkg::CFG_DEPTH: begin
          depth_q    <= cfg_data_i[wts_pkg::DEPTH_W-1:0];
          hist_len_q <= '{default: '0};
          count_q    <= '0;
          head_q     <= '0;
          index_q    <= '0;
        end
        wts_pkg::CFG_MAX_STEP: ms_q <= cfg_data_i[PW-1:0];
        wts_pkg::CFG_WEIGHT:   wt_q <= cfg_data_i;
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      if (fend_q) begin
        hist_len_q[head_q] <= frame_len;
        head_q  <= (32'(head_q) == MAX_HISTORY - 1) ? '0 : head_q + SLOT_W'(1);
        count_q <= held;
        if (active) begin
          stable_len_q <= frame_len;
        end
        index_q <= '0;
      end else if (in_range) begin
        index_q <= index_q + IDX_W'(1);
      end
    end
  end

  // Frame memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) begin
      hist_x_mem[head_q][pt] <= px_q;
      hist_y_mem[head_q][pt] <= py_q;
    end
    if (cmd_i.hist_rd) begin
      rd_x_q <= hist_x_mem[slot][pt];
      rd_y_q <= hist_y_mem[slot][pt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stab_wr) begin
      stab_x_mem[pt] <= rx_q;
      stab_y_mem[pt] <= ry_q;
    end
    if (cmd_i.stab_rd) begin
      lx_q <= stab_x_mem[pt];
      ly_q <= stab_y_mem[pt];
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      wts_pkg::DIV_MEAN_X: begin
        div_dividend = wts_pkg::DIVD_W'(sx_q);
        div_divisor  = wts_pkg::DIVS_W'(cnt_q);
      end
      wts_pkg::DIV_MEAN_Y: begin
        div_dividend = wts_pkg::DIVD_W'(sy_q);
        div_divisor  = wts_pkg::DIVS_W'(cnt_q);
      end
      wts_pkg::DIV_STEP_X: begin
        div_dividend = prodx_q;
        div_divisor  = dist_q;
      end
      default: begin
        div_dividend = prody_q;
        div_divisor  = dist_q;
      end
    endcase
  end

  wts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  wts_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .value_i (d2_q),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      fend_q <= frame_end_i;
      rx_q   <= pos_x_i;
      ry_q   <= pos_y_i;
      sx_q   <= SUM_W'(pos_x_i);
      sy_q   <= SUM_W'(pos_y_i);
      cnt_q  <= CNT_W'(1);
      j_q    <= CNT_W'(1);
    end
    if (cmd_i.j_inc) begin
      j_q <= j_q + CNT_W'(1);
    end
    if (cmd_i.acc) begin
      sx_q  <= sx_q + SUM_W'(rd_x_q);
      sy_q  <= sy_q + SUM_W'(rd_y_q);
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        wts_pkg::DIV_MEAN_X: rx_q <= div_quo[PW-1:0];
        wts_pkg::DIV_MEAN_Y: ry_q <= div_quo[PW-1:0];
        wts_pkg::DIV_STEP_X: rx_q <= negx_q ? lx_q - div_quo[PW-1:0] : lx_q + div_quo[PW-1:0];
        default:             ry_q <= negy_q ? ly_q - div_quo[PW-1:0] : ly_q + div_quo[PW-1:0];
      endcase
    end
    if (cmd_i.diff) begin
      negx_q <= rx_q < lx_q;
      negy_q <= ry_q < ly_q;
      magx_q <= (rx_q < lx_q) ? lx_q - rx_q : rx_q - lx_q;
      magy_q <= (ry_q < ly_q) ? ly_q - ry_q : ry_q - ly_q;
    end
    if (cmd_i.square) begin
      sqx_q <= magx_q * magx_q;
      sqy_q <= magy_q * magy_q;
      ms2_q <= ms_q * ms_q;
    end
    if (cmd_i.d2_sum) begin
      d2_q <= wts_pkg::D2_W'(sqx_q) + wts_pkg::D2_W'(sqy_q);
    end
    if (cmd_i.sqrt_take) begin
      dist_q <= sqrt_root;
    end
    if (cmd_i.step_mul) begin
      prodx_q <= magx_q * ms_q;
      prody_q <= magy_q * ms_q;
    end
    if (cmd_i.blend_mul) begin
      bx1_q <= w_eff * rx_q;
      bx2_q <= w_inv * lx_q;
      by1_q <= w_eff * ry_q;
      by2_q <= w_inv * ly_q;
    end
    if (cmd_i.blend_sum) begin
      rx_q <= bsum_x[2*PW-1:PW];
      ry_q <= bsum_y[2*PW-1:PW];
    end
    if (cmd_i.out_load) begin
      out_x_q    <= rx_q;
      out_y_q    <= ry_q;
      out_last_q <= fend_q;
    end
  end

  assign out_x_o    = out_x_q;
  assign out_y_o    = out_y_q;
  assign out_last_o = out_last_q;
endmodule

>>> sv/wts_ctrl.sv
// Controller: sequences one waypoint at a time through the datapath.
// Depends on wts_pkg for the state, command and status types.
module wts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wts_pkg::sts_t sts_i,
  output wts_pkg::cmd_t cmd_o
);
  wts_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = wts_pkg::DIV_MEAN_X;
    in_ready_o    = 1'b0;
    unique case (state_q)
      wts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wts_pkg::S_DECIDE;
        end
      end
      wts_pkg::S_DECIDE: begin
        if (!sts_i.enabled) begin
          state_d = wts_pkg::S_OUT;
        end else if (!sts_i.in_range) begin
          state_d = wts_pkg::S_FINISH;
        end else begin
          cmd_o.hist_wr = 1'b1;
          cmd_o.stab_rd = 1'b1;
          state_d = sts_i.active ? wts_pkg::S_RD : wts_pkg::S_FINISH;
        end
      end
      wts_pkg::S_RD: begin
        if (sts_i.more_j) begin
          cmd_o.j_inc   = 1'b1;
          cmd_o.hist_rd = sts_i.len_ok;
          state_d = sts_i.len_ok ? wts_pkg::S_ACC : wts_pkg::S_RD;
        end else begin
          state_d = wts_pkg::S_MX_GO;
        end
      end
      wts_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = wts_pkg::S_RD;
      end
      wts_pkg::S_MX_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = wts_pkg::S_MX_WAIT;
      end
      wts_pkg::S_MX_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = wts_pkg::S_MY_GO;
        end
      end
      wts_pkg::S_MY_GO: begin
        cmd_o.div_sel = wts_pkg::DIV_MEAN_Y;
        cmd_o.div_go  = 1'b1;
        state_d       = wts_pkg::S_MY_WAIT;
      end
      wts_pkg::S_MY_WAIT: begin
        cmd_o.div_sel = wts_pkg::DIV_MEAN_Y;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = sts_i.has_stable ? wts_pkg::S_DIFF : wts_pkg::S_STAB_WR;
        end
      end
      wts_pkg::S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = wts_pkg::S_SQUARE;
      end
      wts_pkg::S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = wts_pkg::S_SUM;
      end
      wts_pkg::S_SUM: begin
        cmd_o.d2_sum = 1'b1;
        state_d      = wts_pkg::S_CHECK;
      end
      wts_pkg::S_CHECK: begin
        state_d = sts_i.clamp ? wts_pkg::S_SQRT_GO : wts_pkg::S_BLEND;
      end
      wts_pkg::S_SQRT_GO: begin
        cmd_o.sqrt_go = 1'b1;
        state_d       = wts_pkg::S_SQRT_WAIT;
      end
      wts_pkg::S_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.sqrt_take = 1'b1;
          state_d         = wts_pkg::S_MUL;
        end
      end
      wts_pkg::S_MUL: begin
        cmd_o.step_mul = 1'b1;
        state_d        = wts_pkg::S_SX_GO;
      end
      wts_pkg::S_SX_GO: begin
        cmd_o.div_sel = wts_pkg::DIV_STEP_X;
        cmd_o.div_go  = 1'b1;
        state_d       = wts_pkg::S_SX_WAIT;
      end
      wts_pkg::S_SX_WAIT: begin
        cmd_o.div_sel = wts_pkg::DIV_STEP_X;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = wts_pkg::S_SY_GO;
        end
      end
      wts_pkg::S_SY_GO: begin
        cmd_o.div_sel = wts_pkg::DIV_STEP_Y;
        cmd_o.div_go  = 1'b1;
        state_d       = wts_pkg::S_SY_WAIT;
      end
      wts_pkg::S_SY_WAIT: begin
        cmd_o.div_sel = wts_pkg::DIV_STEP_Y;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = wts_pkg::S_BLEND;
        end
      end
      wts_pkg::S_BLEND: begin
        cmd_o.blend_mul = 1'b1;
        state_d         = wts_pkg::S_BSUM;
      end
      wts_pkg::S_BSUM: begin
        cmd_o.blend_sum = 1'b1;
        state_d         = wts_pkg::S_STAB_WR;
      end
      wts_pkg::S_STAB_WR: begin
        cmd_o.stab_wr = 1'b1;
        state_d       = wts_pkg::S_FINISH;
      end
      wts_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = wts_pkg::S_OUT;
      end
      wts_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = wts_pkg::S_IDLE;
        end
      end
      default: state_d = wts_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

>>> sv/waypoint_temporal_stabilizer.sv
// Waypoint temporal stabilizer. One request is worked on at a time, and the next is taken in
// the cycle after a result is loaded; an output register holds that result while it waits.
// Disabled, with a short history or past capacity, a point passes through; else the mean over
// the history frames holding it is blended with the stable point, if any, its step clamped
// first when too long (32-step divider, 17-step square root). A result is offered in the same
// cycle as the next request can be taken. Reset restores the defaults, empties the history.
module waypoint_temporal_stabilizer #(
  parameter int MAX_HISTORY = 8,
  parameter int MAX_POINTS  = 64,
  parameter int MIN_FRAMES  = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wts_in_if.sink                         in_if,
  wts_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [wts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wts_pkg::CFG_DATA_W-1:0] cfg_data_i
);
`include "assert_macros.svh"

  // The controller and datapath talk only through these two structs.
  wts_pkg::cmd_t cmd;
  wts_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  // The controller walks one request through history gathering, the mean
  // division, the optional clamp and blend, then parks the result.
  wts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the frame ring, the last stable
  // frame, the shared divider and the square root unit.
  wts_datapath #(
    .MAX_HISTORY (MAX_HISTORY),
    .MAX_POINTS  (MAX_POINTS),
    .MIN_FRAMES  (MIN_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pos_x_i     (in_if.pos_x),
    .pos_y_i     (in_if.pos_y),
    .frame_end_i (in_if.frame_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_x_o     (out_if.out_x),
    .out_y_o     (out_if.out_y),
    .out_last_o  (out_if.out_last)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // Only one request may be in work at any time.
  `WTS_ASSERT_NXT(a_single_request, clk_i, rst_ni, in_if.valid && in_if.ready, !in_if.ready, "second request taken while one is in work")
  // The controller never fires two start or transfer strobes together.
  `WTS_ASSERT(a_one_strobe, clk_i, rst_ni, $onehot0({cmd.load, cmd.div_go, cmd.sqrt_go, cmd.out_load}), "conflicting controller strobes")
  // The square root only runs for a step that needs clamping.
  `WTS_ASSERT_IMP(a_sqrt_clamp, clk_i, rst_ni, sts.sqrt_done, sts.clamp, "square root finished without a clamp")
endmodule
